FILE: sv/srgb_to_cie_xy_chromaticity_macros.svh
// Assertion macros shared by the checker of the sRGB to CIE xy converter.
// Depends on nothing; the macros expect clk_i and rst_ni in the using scope.
`ifndef SRGB_TO_CIE_XY_CHROMATICITY_MACROS_SVH
`define SRGB_TO_CIE_XY_CHROMATICITY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SXY_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SXY_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sxy_pkg.sv
// Shared constants, types, linearization ROM and matrix coefficients for the
// sRGB to CIE xy converter. Depends on nothing.
package sxy_pkg;

  // Internal fixed-point precision of the linear values and the matrix.
  localparam int FRAC_BITS = 16;
  // Output precision is always Q0.16.
  localparam int OUT_BITS  = 16;

  localparam int CHAN_W = 8;
  localparam int LIN_W  = FRAC_BITS + 1;
  localparam int COEF_W = FRAC_BITS + 1;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  // Wide enough for (2n+1)^5 * 269025^12 and for a^12 * 2^(5F+5).
  localparam int BIG_W  = 5 * FRAC_BITS + 5 + 12 * 19 + 8;

  localparam int unsigned LIN_DEN = 269025;

  typedef logic [255:0][LIN_W-1:0] lin_rom_t;

  // Status that travels with a quotient through the divider.
  typedef struct packed {
    logic black;
    logic sat_x;
    logic sat_y;
  } div_flags_t;

  // Linear segment of the transfer curve, rounded to nearest.
  function automatic logic [31:0] lin_linear(input int unsigned c);
    logic [63:0] num;
    num = (64'(c) * 64'd200) << FRAC_BITS;
    num = num + 64'd329460;
    return 32'(num / 64'd658920);
  endfunction

  // Power segment: smallest n with (2n+1)^5 * b^12 > 2^(5F+5) * a^12.
  function automatic logic [31:0] lin_power(input int unsigned c);
    logic [BIG_W-1:0] t;
    logic [BIG_W-1:0] u;
    logic [BIG_W-1:0] m;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic [31:0]      mid;
    t = BIG_W'(1);
    for (int i = 0; i < 12; i++) t = t * BIG_W'(1000 * c + 14025);
    t = t << (5 * FRAC_BITS + 5);
    lo = 32'd0;
    hi = (32'd1 << FRAC_BITS) + 32'd1;
    for (int it = 0; it < FRAC_BITS + 2; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        m = BIG_W'({mid, 1'b1});
        u = BIG_W'(1);
        for (int i = 0; i < 5; i++) u = u * m;
        for (int i = 0; i < 12; i++) u = u * BIG_W'(LIN_DEN);
        if (u > t) hi = mid;
        else lo = mid + 32'd1;
      end
    end
    return lo;
  endfunction

  // Build the whole linearization ROM at elaboration.
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    rom = '0;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) rom[c] = LIN_W'(lin_linear(c));
      else rom[c] = LIN_W'(lin_power(c));
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

  // Matrix coefficient from millionths, rounded to nearest.
  function automatic logic [COEF_W-1:0] coef(input logic [31:0] millionths);
    logic [63:0] v;
    v = (64'(millionths) << (FRAC_BITS + 1)) + 64'd1000000;
    v = v / 64'd2000000;
    return COEF_W'(v);
  endfunction

  localparam logic [COEF_W-1:0] COEF_XR = coef(32'd649926);
  localparam logic [COEF_W-1:0] COEF_XG = coef(32'd103455);
  localparam logic [COEF_W-1:0] COEF_XB = coef(32'd197109);
  localparam logic [COEF_W-1:0] COEF_YR = coef(32'd234327);
  localparam logic [COEF_W-1:0] COEF_YG = coef(32'd743075);
  localparam logic [COEF_W-1:0] COEF_YB = coef(32'd22598);
  localparam logic [COEF_W-1:0] COEF_ZG = coef(32'd53077);
  localparam logic [COEF_W-1:0] COEF_ZB = coef(32'd1035763);

endpackage

FILE: sv/sxy_front.sv
// Front pipeline: ROM linearization, matrix products, X/Y/Z sums and total.
// Depends on sxy_pkg.
module sxy_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [sxy_pkg::CHAN_W-1:0] red_i,
  input  logic [sxy_pkg::CHAN_W-1:0] green_i,
  input  logic [sxy_pkg::CHAN_W-1:0] blue_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [sxy_pkg::SUM_W-1:0] x_o,
  output logic [sxy_pkg::SUM_W-1:0] y_o,
  output logic [sxy_pkg::SUM_W-1:0] s_o
);

  localparam int NSTG = 4;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] ld;

  logic [sxy_pkg::LIN_W-1:0]  lr_q, lg_q, lb_q;
  logic [sxy_pkg::PROD_W-1:0] pxr_q, pxg_q, pxb_q, pyr_q, pyg_q, pyb_q, pzg_q, pzb_q;
  logic [sxy_pkg::SUM_W-1:0]  xa_q, ya_q, za_q;
  logic [sxy_pkg::SUM_W-1:0]  xb_q, yb_q, s_q;

  // A stage loads when it is empty or when some stage below it can move.
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      ld[k] = !stall_i || (((~v_q) >> k) != '0);
    end
  end

  assign stall_o = !ld[0];

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0 reads the ROM, stage 1 multiplies by the matrix.
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      lr_q <= sxy_pkg::LIN_ROM[red_i];
      lg_q <= sxy_pkg::LIN_ROM[green_i];
      lb_q <= sxy_pkg::LIN_ROM[blue_i];
    end
    if (ld[1]) begin
      pxr_q <= sxy_pkg::PROD_W'(lr_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_XR);
      pxg_q <= sxy_pkg::PROD_W'(lg_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_XG);
      pxb_q <= sxy_pkg::PROD_W'(lb_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_XB);
      pyr_q <= sxy_pkg::PROD_W'(lr_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_YR);
      pyg_q <= sxy_pkg::PROD_W'(lg_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_YG);
      pyb_q <= sxy_pkg::PROD_W'(lb_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_YB);
      pzg_q <= sxy_pkg::PROD_W'(lg_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_ZG);
      pzb_q <= sxy_pkg::PROD_W'(lb_q) * sxy_pkg::PROD_W'(sxy_pkg::COEF_ZB);
    end
  end

  // Stage 2 sums each matrix row, stage 3 forms the total.
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      xa_q <= sxy_pkg::SUM_W'(pxr_q) + sxy_pkg::SUM_W'(pxg_q) + sxy_pkg::SUM_W'(pxb_q);
      ya_q <= sxy_pkg::SUM_W'(pyr_q) + sxy_pkg::SUM_W'(pyg_q) + sxy_pkg::SUM_W'(pyb_q);
      za_q <= sxy_pkg::SUM_W'(pzg_q) + sxy_pkg::SUM_W'(pzb_q);
    end
    if (ld[3]) begin
      xb_q <= xa_q;
      yb_q <= ya_q;
      s_q  <= xa_q + ya_q + za_q;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign x_o     = xb_q;
  assign y_o     = yb_q;
  assign s_o     = s_q;

endmodule

FILE: sv/sxy_div.sv
// Dual-lane pipelined restoring divider: one quotient bit per stage for x and y.
// Depends on sxy_pkg.
module sxy_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [sxy_pkg::SUM_W-1:0]   x_i,
  input  logic [sxy_pkg::SUM_W-1:0]   y_i,
  input  logic [sxy_pkg::SUM_W-1:0]   s_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [sxy_pkg::OUT_BITS-1:0] chroma_x_o,
  output logic [sxy_pkg::OUT_BITS-1:0] chroma_y_o,
  output logic                        is_black_o
);

  // One setup stage followed by one stage per quotient bit.
  localparam int NSTG = sxy_pkg::OUT_BITS + 1;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] ld;

  logic [sxy_pkg::SUM_W-1:0]    rx_q  [NSTG];
  logic [sxy_pkg::SUM_W-1:0]    ry_q  [NSTG];
  logic [sxy_pkg::SUM_W-1:0]    den_q [NSTG];
  logic [sxy_pkg::OUT_BITS-1:0] qx_q  [NSTG];
  logic [sxy_pkg::OUT_BITS-1:0] qy_q  [NSTG];
  sxy_pkg::div_flags_t          fl_q  [NSTG];

  logic [sxy_pkg::SUM_W-1:0]    rx_d  [NSTG];
  logic [sxy_pkg::SUM_W-1:0]    ry_d  [NSTG];
  logic [sxy_pkg::OUT_BITS-1:0] qx_d  [NSTG];
  logic [sxy_pkg::OUT_BITS-1:0] qy_d  [NSTG];
  logic [sxy_pkg::SUM_W:0]      shx   [NSTG];
  logic [sxy_pkg::SUM_W:0]      shy   [NSTG];
  logic [sxy_pkg::SUM_W:0]      dext  [NSTG];
  sxy_pkg::div_flags_t          fl_d;

  // A stage loads when it is empty or when some stage below it can move.
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      ld[k] = !stall_i || (((~v_q) >> k) != '0);
    end
  end

  assign stall_o = !ld[0];

  // Setup: black when the total is zero, saturation when a ratio reaches one.
  always_comb begin
    fl_d.black = (s_i == '0);
    fl_d.sat_x = (x_i >= s_i);
    fl_d.sat_y = (y_i >= s_i);
  end

  // One restoring step per stage after setup on both lanes, sharing the denominator.
  always_comb begin
    rx_d[0] = x_i;
    ry_d[0] = y_i;
    qx_d[0] = '0;
    qy_d[0] = '0;
    shx[0]  = '0;
    shy[0]  = '0;
    dext[0] = '0;
    for (int k = 1; k < NSTG; k++) begin
      shx[k]  = {rx_q[k-1], 1'b0};
      shy[k]  = {ry_q[k-1], 1'b0};
      dext[k] = {1'b0, den_q[k-1]};
      if (shx[k] >= dext[k]) begin
        rx_d[k] = sxy_pkg::SUM_W'(shx[k] - dext[k]);
        qx_d[k] = {qx_q[k-1][sxy_pkg::OUT_BITS-2:0], 1'b1};
      end else begin
        rx_d[k] = sxy_pkg::SUM_W'(shx[k]);
        qx_d[k] = {qx_q[k-1][sxy_pkg::OUT_BITS-2:0], 1'b0};
      end
      if (shy[k] >= dext[k]) begin
        ry_d[k] = sxy_pkg::SUM_W'(shy[k] - dext[k]);
        qy_d[k] = {qy_q[k-1][sxy_pkg::OUT_BITS-2:0], 1'b1};
      end else begin
        ry_d[k] = sxy_pkg::SUM_W'(shy[k]);
        qy_d[k] = {qy_q[k-1][sxy_pkg::OUT_BITS-2:0], 1'b0};
      end
    end
  end

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      den_q[0] <= s_i;
      fl_q[0]  <= fl_d;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        den_q[k] <= den_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
    end
    for (int k = 0; k < NSTG; k++) begin
      if (ld[k]) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
      end
    end
  end

  // Black forces zeros; a saturated ratio reads as all ones.
  always_comb begin
    if (fl_q[NSTG-1].black) begin
      chroma_x_o = '0;
      chroma_y_o = '0;
    end else begin
      chroma_x_o = fl_q[NSTG-1].sat_x ? '1 : qx_q[NSTG-1];
      chroma_y_o = fl_q[NSTG-1].sat_y ? '1 : qy_q[NSTG-1];
    end
  end

  assign is_black_o = fl_q[NSTG-1].black;
  assign valid_o    = v_q[NSTG-1];

endmodule

FILE: sv/srgb_to_cie_xy_chromaticity.sv
// sRGB to CIE xy chromaticity converter, 21 register stages deep.
// Throughput: one request per cycle when not stalled; one quotient bit per stage.
// Stalls fill empty stages first, so input is taken while a result waits.
// Reset clears the valid bits only; the ROM and coefficients are constants.
module srgb_to_cie_xy_chromaticity (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sxy_pkg::CHAN_W-1:0]   red_i,
  input  logic [sxy_pkg::CHAN_W-1:0]   green_i,
  input  logic [sxy_pkg::CHAN_W-1:0]   blue_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sxy_pkg::OUT_BITS-1:0] chroma_x_o,
  output logic [sxy_pkg::OUT_BITS-1:0] chroma_y_o,
  output logic                         is_black_o
);

  logic                      mid_valid;
  logic                      mid_stall;
  logic [sxy_pkg::SUM_W-1:0] mid_x;
  logic [sxy_pkg::SUM_W-1:0] mid_y;
  logic [sxy_pkg::SUM_W-1:0] mid_s;

  // Linearization and matrix.
  sxy_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (mid_valid),
    .stall_i (mid_stall),
    .x_o     (mid_x),
    .y_o     (mid_y),
    .s_o     (mid_s)
  );

  // Chromaticity ratios.
  sxy_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mid_valid),
    .stall_o    (mid_stall),
    .x_i        (mid_x),
    .y_i        (mid_y),
    .s_i        (mid_s),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .chroma_x_o (chroma_x_o),
    .chroma_y_o (chroma_y_o),
    .is_black_o (is_black_o)
  );

endmodule

FILE: sv/sxy_checker.sv
// Port-level checker for the sRGB to CIE xy converter, bound to the top level.
// Depends on sxy_pkg and srgb_to_cie_xy_chromaticity_macros.svh.
`include "srgb_to_cie_xy_chromaticity_macros.svh"

module sxy_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sxy_pkg::OUT_BITS-1:0] chroma_x_o,
  input logic [sxy_pkg::OUT_BITS-1:0] chroma_y_o,
  input logic                         is_black_o
);

  // A black result carries zero chromaticity.
  `SXY_ASSERT_NOW(a_black_zero, out_valid_o && is_black_o, chroma_x_o == '0 && chroma_y_o == '0, "black result with nonzero chromaticity")

  // Every primary adds to Y, so a lit color never has zero y.
  `SXY_ASSERT_NOW(a_lit_y_nonzero, out_valid_o && !is_black_o, chroma_y_o != '0, "lit color with zero y")

  // A stalled result stays put until it is taken.
  `SXY_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(chroma_x_o) && $stable(chroma_y_o) && $stable(is_black_o), "stalled result changed")

endmodule

bind srgb_to_cie_xy_chromaticity sxy_checker u_checker (.*);

FILE: sim/tb_srgb_to_cie_xy_chromaticity.sv
// Self-checking testbench for the sRGB to CIE xy chromaticity converter.
// Depends on sxy_pkg and srgb_to_cie_xy_chromaticity; it builds its own
// linearization table and matrix to predict each result not hand-typed.
module tb_srgb_to_cie_xy_chromaticity;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 3000;

  // One expected result as the block presents it.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        black;
  } chroma_t;

  // One directed request, with a hand-typed result where it is obvious.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;
    chroma_t    want;
  } directed_row_t;

  localparam int ROWS = 19;
  localparam directed_row_t DIRECTED_ROWS [ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd0, 1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd1,   8'd1,   1'b0, '0},
    '{8'd10,  8'd10,  8'd10,  1'b0, '0},
    '{8'd11,  8'd11,  8'd11,  1'b0, '0},
    '{8'd10,  8'd0,   8'd0,   1'b0, '0},
    '{8'd11,  8'd0,   8'd0,   1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd254, 8'd1,   8'd128, 1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd0, 1'b1}}
  };

  localparam logic [7:0] CORNER_CODES [6] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd254, 8'd255};

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [sxy_pkg::CHAN_W-1:0]   red_i;
  logic [sxy_pkg::CHAN_W-1:0]   green_i;
  logic [sxy_pkg::CHAN_W-1:0]   blue_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [sxy_pkg::OUT_BITS-1:0] chroma_x_o;
  logic [sxy_pkg::OUT_BITS-1:0] chroma_y_o;
  logic                         is_black_o;

  longint unsigned linear_lut [256];
  chroma_t         pending_chroma [$];
  chroma_t         oldest;
  int              mismatch_count;
  bit              hold_off_req;

  srgb_to_cie_xy_chromaticity dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .chroma_x_o (chroma_x_o),
    .chroma_y_o (chroma_y_o),
    .is_black_o (is_black_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // True when (2n+1)^5 * 269025^12 exceeds the target, i.e. n is past the
  // exact rounded value of the power segment.
  function automatic bit past_target(input longint unsigned n, input logic [319:0] target);
    logic [319:0] p;
    p = 320'd1;
    for (int k = 0; k < 5; k++) p = p * 320'(2 * n + 1);
    for (int k = 0; k < 12; k++) p = p * 320'd269025;
    return p > target;
  endfunction

  // Fill the table: linear segment directly, power segment from a real
  // estimate that is then corrected by exact integer comparison.
  task automatic fill_linear_lut();
    logic [319:0]    target;
    longint unsigned n;
    real             v;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        linear_lut[c] = (longint'(c) * 64'd13107200 + 64'd329460) / 64'd658920;
      end else begin
        target = 320'd1;
        for (int k = 0; k < 12; k++) target = target * 320'(1000 * c + 14025);
        target = target << 85;
        v = (1000.0 * c + 14025.0) / 269025.0;
        n = $rtoi((v ** 2.4) * 65536.0);
        while (!past_target(n, target)) n++;
        while (n > 0 && past_target(n - 1, target)) n--;
        linear_lut[c] = n;
      end
    end
  endtask

  // Matrix coefficient from millionths, rounded to nearest in Q.16.
  function automatic longint unsigned coef_q16(input longint unsigned millionths);
    return (millionths * 64'd131072 + 64'd1000000) / 64'd2000000;
  endfunction

  // Q0.16 share of the sum, saturated just below one.
  function automatic logic [15:0] share_q16(input longint unsigned part,
                                            input longint unsigned total);
    longint unsigned q;
    if (part >= total) return 16'hFFFF;
    q = (part << 16) / total;
    return q[15:0];
  endfunction

  // Expected chromaticity of one gamma-encoded triple.
  function automatic chroma_t predict_chroma(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    longint unsigned lr;
    longint unsigned lg;
    longint unsigned lb;
    longint unsigned cx;
    longint unsigned cy;
    longint unsigned cz;
    longint unsigned total;
    chroma_t         res;
    lr = linear_lut[r];
    lg = linear_lut[g];
    lb = linear_lut[b];
    cx = coef_q16(649926) * lr + coef_q16(103455) * lg + coef_q16(197109) * lb;
    cy = coef_q16(234327) * lr + coef_q16(743075) * lg + coef_q16(22598) * lb;
    cz = coef_q16(53077) * lg + coef_q16(1035763) * lb;
    total = cx + cy + cz;
    if (total == 0) begin
      res = '{16'd0, 16'd0, 1'b1};
    end else begin
      res = '{share_q16(cx, total), share_q16(cy, total), 1'b0};
    end
    return res;
  endfunction

  // Random triple, biased to corners, near-black, grays, single channels.
  function automatic logic [23:0] random_rgb();
    int          sel;
    logic [7:0]  v;
    logic [23:0] rgb;
    sel = $urandom_range(0, 9);
    v = 8'($urandom());
    if (sel < 6) begin
      rgb = 24'($urandom());
    end else if (sel == 6) begin
      rgb = {CORNER_CODES[$urandom_range(0, 5)], CORNER_CODES[$urandom_range(0, 5)],
             CORNER_CODES[$urandom_range(0, 5)]};
    end else if (sel == 7) begin
      rgb = {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)), 8'($urandom_range(0, 12))};
    end else if (sel == 8) begin
      rgb = {v, v, v};
    end else begin
      rgb = 24'(v) << (8 * $urandom_range(0, 2));
    end
    return rgb;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int next_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and record its expected result when it is taken.
  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic typed, input chroma_t want);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_chroma.push_back(typed ? want : predict_chroma(r, g, b));
  endtask

  // Drive the request line low, then wait out the idle stretch n.
  task automatic drive_idle(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drive the result stall to a level and hold it for the stretch n.
  task automatic drive_stall(input logic level, input int n);
    if (n > 0) begin
      @(negedge clk_i);
      out_stall_i <= level;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_chroma.size() != 0) @(negedge clk_i);
  endtask

  // Main stimulus: directed rows, then random requests.
  initial begin
    logic [23:0] rgb;
    bit          calm;
    fill_linear_lut();
    mismatch_count = 0;
    hold_off_req   = 1'b0;
    calm           = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    red_i          = '0;
    green_i        = '0;
    blue_i         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < ROWS; i++) begin
      send_rgb(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].g, DIRECTED_ROWS[i].b,
               DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      drive_idle(next_gap());
    end
    drive_idle(1);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // Long receiver hold-off while requests keep coming back to back.
      if (i == 250) begin
        hold_off_req = 1'b1;
        calm         = 1'b1;
      end
      // Let the pipeline empty completely before carrying on.
      if (i == 500) begin
        drive_idle(1);
        wait_drained();
      end
      rgb = random_rgb();
      send_rgb(rgb[23:16], rgb[15:8], rgb[7:0], 1'b0, '0);
      if (!calm) drive_idle(next_gap());
    end
    drive_idle(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_chroma.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side stalls: short runs, calm stretches, one long hold-off.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        drive_stall(1'b1, HOLD_CYCLES);
        hold_off_req = 1'b0;
      end else begin
        drive_stall(1'b0, ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12));
        drive_stall(1'b1, next_gap());
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chroma.size() == 0) begin
        $error("result with no request pending: x=%0d y=%0d black=%0d",
               chroma_x_o, chroma_y_o, is_black_o);
        mismatch_count++;
      end else begin
        oldest = pending_chroma.pop_front();
        if (chroma_x_o !== oldest.x) begin
          $error("chroma_x: expected %0d, actual %0d", oldest.x, chroma_x_o);
          mismatch_count++;
        end
        if (chroma_y_o !== oldest.y) begin
          $error("chroma_y: expected %0d, actual %0d", oldest.y, chroma_y_o);
          mismatch_count++;
        end
        if (is_black_o !== oldest.black) begin
          $error("is_black: expected %0d, actual %0d", oldest.black, is_black_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  initial begin
    int idle_count;
    idle_count = 0;
    while (idle_count < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count = 0;
      else idle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
